// File: hdl/chta_pkg.sv
`timescale 1ns / 1ps
// Package with shared types, constants and helpers for the clustered hash table.
package chta_pkg;

   localparam int unsigned CLUSTERS_DEF     = 1024;
   localparam int unsigned DEPTH_BIAS_DEF   = 8;
   localparam int unsigned WAYS             = 3;

   localparam logic [1:0] OP_PROBE = 2'd0;
   localparam logic [1:0] OP_STORE = 2'd1;
   localparam logic [1:0] OP_NEWGEN = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] BOUND_EXACT = 2'd3;

   // One stored entry, packed as it sits in memory.
   typedef struct packed {
      logic [15:0] tag;
      logic [15:0] mv;
      logic [15:0] score;
      logic [15:0] eval;
      logic [7:0]  depth;
      logic [7:0]  genbound;
   } entry_type;

   // Request registered from the input channel.
   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] tag;
      logic [1:0]  way;
      logic [15:0] move_in;
      logic [15:0] score_in;
      logic [15:0] eval_in;
      logic [8:0]  depth_in;
      logic [1:0]  bound_in;
      logic        pv_in;
   } req_type;

   // Replacement score of an entry: stored depth minus age penalty (10 bits signed).
   function automatic logic signed [9:0] repl_value(input logic [7:0] depth,
                                                    input logic [7:0] genbound,
                                                    input logic [4:0] gen);
      logic [7:0] age;
      age = ({gen, 3'b000} - (genbound & 8'hF8)) & 8'hF8;
      return $signed({2'b00, depth}) - $signed({2'b00, age});
   endfunction

endpackage

// File: hdl/chta_index.sv
`timescale 1ns / 1ps
// Sequential key mod CLUSTERS reduction, one 4-bit key digit per cycle, over the 16 digits of the key.
module chta_index #(
   parameter int unsigned CLUSTERS = chta_pkg::CLUSTERS_DEF,
   parameter int unsigned IW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   key,
   output logic          done,
   output logic [IW-1:0] index
);
   localparam int unsigned RW = IW + 1;
   localparam logic [RW-1:0] MODV = RW'(CLUSTERS);

   // Residue of d * 16**i modulo CLUSTERS for digit position i and digit value d.
   function automatic logic [256*RW-1:0] residue_table();
      logic [256*RW-1:0] t;
      longint unsigned   p;
      longint unsigned   r;
      t = '0;
      p = 64'd1 % CLUSTERS;
      for (int i = 0; i < 16; i++) begin
         for (int d = 0; d < 16; d++) begin
            r = (longint'(d) * p) % CLUSTERS;
            t[(i*16 + d)*RW +: RW] = RW'(r);
         end
         p = (p * 64'd16) % CLUSTERS;
      end
      return t;
   endfunction

   localparam logic [256*RW-1:0] RES_TABLE = residue_table();

   logic [63:0]   key_ff, key_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [3:0]    pos_ff, pos_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] term;
   logic [RW:0]   sum;

   always_comb begin
      key_in  = key_ff;
      rem_in  = rem_ff;
      pos_in  = pos_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      term    = RES_TABLE[{pos_ff, key_ff[3:0]} * RW +: RW];
      sum     = {1'b0, rem_ff} + {1'b0, term};
      if (start) begin
         key_in  = key;
         rem_in  = '0;
         pos_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Both addends are below CLUSTERS, so one subtract brings the sum back in range.
         if (sum >= {1'b0, MODV}) rem_in = RW'(sum - {1'b0, MODV});
         else rem_in = sum[RW-1:0];
         key_in = {4'b0000, key_ff[63:4]};
         pos_in = pos_ff + 4'd1;
         if (pos_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rem_ff <= rem_in;
      pos_ff <= pos_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign index = (CLUSTERS > 1) ? rem_ff[IW-1:0] : '0;
endmodule

// File: hdl/chta_mem.sv
`timescale 1ns / 1ps
// Entry memory: one write and one registered read port.
module chta_mem #(
   parameter int unsigned ENTRIES = chta_pkg::CLUSTERS_DEF * chta_pkg::WAYS,
   parameter int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  chta_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output chta_pkg::entry_type rd_data
);
   import chta_pkg::*;
   entry_type mem [ENTRIES];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// File: hdl/clustered_hash_table_with_aging_core.sv
`timescale 1ns / 1ps
// Top level of the clustered hash table with aging.
//
// A three-way set-associative position cache. Each transaction on the req_ side
// is a probe, a store, a new-search generation step or a table clear; only a
// probe returns a transaction on the rsp_ side. The block handles one request at
// a time: req_tready is high only while the sequencer is idle. The cluster index
// (key mod CLUSTERS) comes from a shared reduction unit that adds one table residue
// per 4-bit key digit. A probe then reads the three ways in turn, each through a
// read state and an evaluate state, over the single read port of the entry memory,
// and stops at the first hit; a hit writes back the refreshed generation before
// the response is shown. A store reads its way, decides and writes; a store to
// way 3 is ignored. After reset and after a clear a clearing pass writes every one
// of the CLUSTERS*3 entries to zero, one entry a cycle, while no request is
// accepted. A finished probe waits in an output register, so the next request is
// accepted while the response is still pending; only a further probe then stalls
// until that response is taken.
module clustered_hash_table_with_aging_core #(
   parameter int unsigned CLUSTERS     = chta_pkg::CLUSTERS_DEF,
   parameter int unsigned DEPTH_BIAS   = chta_pkg::DEPTH_BIAS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[1:0], key[65:2], way[67:66], move_in[83:68], score_in[99:84],
   // eval_in[115:100], depth_in[124:116], bound_in[126:125], pv_in[127]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit[0], slot[2:1], move_out[18:3], score_out[34:19], eval_out[50:35],
   // depth_out[59:51], bound_out[61:60], pv_out[62], zero fill [63]
   output logic [63:0]  rsp_tdata
);
   import chta_pkg::*;

   localparam int unsigned ENTRIES = CLUSTERS * WAYS;
   localparam int unsigned IW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
   localparam logic signed [9:0] OFFS = 10'(DEPTH_BIAS);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_INDEX = 8'b0000_0100,
      ST_READ  = 8'b0000_1000,
      ST_EVAL  = 8'b0001_0000,
      ST_DONE  = 8'b0010_0000,
      ST_WBACK = 8'b0100_0000,
      ST_GEN   = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   logic [4:0]      gen_ff, gen_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [AW-1:0]   base_ff, base_in;
   logic [1:0]      rway_ff, rway_in;     // way whose read is outstanding
   logic            found_ff, found_in;
   logic [1:0]      victim_ff, victim_in;
   logic signed [9:0] best_ff, best_in;
   entry_type       hitent_ff, hitent_in;
   logic [1:0]      hitway_ff, hitway_in;
   logic            ovalid_ff, ovalid_in;
   logic [63:0]     odata_ff, odata_in;

   logic            idx_start, idx_done;
   logic [IW-1:0]   idx;
   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   entry_type       wr_data, rd_data;
   logic [1:0]      rd_way;
   logic signed [9:0] v, sd;
   logic [7:0]      sd8;
   logic [7:0]      gb;
   logic            tag_eq;

   chta_index #(.CLUSTERS(CLUSTERS), .IW(IW)) u_index (
      .clock(clock), .reset(reset), .start(idx_start), .key(req_tdata[65:2]),
      .done(idx_done), .index(idx)
   );

   chta_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign idx_start  = req_tvalid && req_tready &&
                       (req_tdata[1:0] == OP_PROBE || req_tdata[1:0] == OP_STORE);
   assign rd_addr    = base_ff + AW'(rd_way);
   assign tag_eq     = (rd_data.tag == req_ff.tag);

   // Saturated stored depth of a store.
   always_comb begin
      sd = $signed({req_ff.depth_in[8], req_ff.depth_in}) + OFFS;
      if (sd < 0) sd8 = 8'd0;
      else if (sd > 10'sd255) sd8 = 8'd255;
      else sd8 = sd[7:0];
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      gen_in    = gen_ff;
      clr_in    = clr_ff;
      base_in   = base_ff;
      rway_in   = rway_ff;
      found_in  = found_ff;
      victim_in = victim_ff;
      best_in   = best_ff;
      hitent_in = hitent_ff;
      hitway_in = hitway_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      rd_way    = rway_ff;
      wr_en     = 1'b0;
      wr_addr   = clr_ff;
      wr_data   = '0;
      v         = repl_value(rd_data.depth, rd_data.genbound, gen_ff);
      gb        = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               req_in.operation = req_tdata[1:0];
               req_in.tag       = req_tdata[65:50];
               req_in.way       = req_tdata[67:66];
               req_in.move_in   = req_tdata[83:68];
               req_in.score_in  = req_tdata[99:84];
               req_in.eval_in   = req_tdata[115:100];
               req_in.depth_in  = req_tdata[124:116];
               req_in.bound_in  = req_tdata[126:125];
               req_in.pv_in     = req_tdata[127];
               case (req_tdata[1:0])
                  OP_PROBE, OP_STORE: state_in = ST_INDEX;
                  OP_NEWGEN: state_in = ST_GEN;
                  default: begin
                     gen_in   = '0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_GEN: begin
            gen_in   = gen_ff + 5'd1;
            state_in = ST_IDLE;
         end
         ST_INDEX: begin
            if (idx_done) begin
               base_in  = AW'({idx, 1'b0}) + AW'(idx);
               found_in = 1'b0;
               if (req_ff.operation == OP_STORE) begin
                  if (req_ff.way == 2'd3) state_in = ST_IDLE;
                  else begin
                     rway_in  = req_ff.way;
                     state_in = ST_READ;
                  end
               end else begin
                  rway_in  = 2'd0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // Address presented this cycle; data is registered next cycle.
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (req_ff.operation == OP_STORE) begin
               wr_en   = 1'b1;
               wr_addr = rd_addr;
               wr_data = rd_data;
               if (req_ff.move_in != 16'd0 || !tag_eq) wr_data.mv = req_ff.move_in;
               if (!(req_ff.bound_in != BOUND_EXACT && tag_eq &&
                     $signed({2'b00, sd8}) < $signed({2'b00, rd_data.depth}) - 10'sd2))
               begin
                  wr_data.tag      = req_ff.tag;
                  wr_data.score    = req_ff.score_in;
                  wr_data.eval     = req_ff.eval_in;
                  wr_data.depth    = sd8;
                  wr_data.genbound = {gen_ff, req_ff.pv_in, req_ff.bound_in};
               end
               state_in = ST_IDLE;
            end else begin
               if (tag_eq && rd_data.genbound[1:0] != 2'b00) begin
                  hitent_in = rd_data;
                  hitway_in = rway_ff;
                  found_in  = 1'b1;
                  state_in  = ST_WBACK;
               end else begin
                  if (rway_ff == 2'd0 || v < best_ff) begin
                     best_in   = v;
                     victim_in = rway_ff;
                  end
                  if (rway_ff == 2'd2) state_in = ST_DONE;
                  else begin
                     rway_in  = rway_ff + 2'd1;
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_WBACK: begin
            gb = {gen_ff, hitent_ff.genbound[2:0]};
            wr_en   = 1'b1;
            wr_addr = base_ff + AW'(hitway_ff);
            wr_data = hitent_ff;
            wr_data.genbound = gb;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               if (found_ff) begin
                  gb = {gen_ff, hitent_ff.genbound[2:0]};
                  odata_in = {1'b0, gb[2], gb[1:0],
                              9'($signed({2'b00, hitent_ff.depth}) - OFFS),
                              hitent_ff.eval, hitent_ff.score, hitent_ff.mv,
                              hitway_ff, 1'b1};
               end else begin
                  odata_in = {61'd0, victim_ff, 1'b0};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      base_ff   <= base_in;
      rway_ff   <= rway_in;
      found_ff  <= found_in;
      victim_ff <= victim_in;
      best_ff   <= best_in;
      hitent_ff <= hitent_in;
      hitway_ff <= hitway_in;
      odata_ff  <= odata_in;
      if (reset) begin
         state_ff  <= ST_CLEAR;
         gen_ff    <= '0;
         clr_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         gen_ff    <= gen_in;
         clr_ff    <= clr_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
endmodule

// File: hdl/chta_checker.sv
`timescale 1ns / 1ps
// Port checker for the clustered hash table, bound to the top level.
module chta_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[63:3] == '0)
      else $error("miss response carries entry data");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:1] != 2'd3)
      else $error("response slot out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on back-to-back cycles");
endmodule

bind clustered_hash_table_with_aging_core chta_checker u_chta_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
